// File: rtl/core/q2e_pkg.sv
package q2e_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TAB_LEN = 30;
  localparam int unsigned TERM_W = 36;
  localparam int unsigned CW = 40;
  localparam int unsigned ACC_W = 33;
  localparam int unsigned SQ_W = 57;
  localparam int unsigned ROOT_W = 29;

  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [TERM_W-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

  function automatic logic signed [ACC_W-1:0] atan_tab(input int unsigned i);
    logic signed [ACC_W-1:0] r;
    case (i)
      0: r = 33'sh3243F6A8;
      1: r = 33'sh1DAC6705;
      2: r = 33'sh0FADBAFC;
      3: r = 33'sh07F56EA6;
      4: r = 33'sh03FEAB76;
      5: r = 33'sh01FFD55B;
      6: r = 33'sh00FFFAAA;
      7: r = 33'sh007FFF55;
      8: r = 33'sh003FFFEA;
      9: r = 33'sh001FFFFD;
      10: r = 33'sh000FFFFF;
      11: r = 33'sh0007FFFF;
      12: r = 33'sh0003FFFF;
      13: r = 33'sh0001FFFF;
      14: r = 33'sh0000FFFF;
      15: r = 33'sh00007FFF;
      16: r = 33'sh00003FFF;
      17: r = 33'sh00001FFF;
      18: r = 33'sh00000FFF;
      19: r = 33'sh000007FF;
      20: r = 33'sh000003FF;
      21: r = 33'sh000001FF;
      22: r = 33'sh000000FF;
      23: r = 33'sh0000007F;
      24: r = 33'sh0000003F;
      25: r = 33'sh0000001F;
      26: r = 33'sh0000000F;
      27: r = 33'sh00000008;
      28: r = 33'sh00000004;
      29: r = 33'sh00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic zero;
  } cordic_t;

endpackage

// File: rtl/core/q2e_terms.sv
// Two register stages: component products, then the sums.
module q2e_terms (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  input  logic signed [15:0] w,
  output logic out_valid,
  output logic signed [q2e_pkg::TERM_W-1:0] sinr,
  output logic signed [q2e_pkg::TERM_W-1:0] cosr,
  output logic signed [q2e_pkg::TERM_W-1:0] sinp,
  output logic signed [q2e_pkg::TERM_W-1:0] siny,
  output logic signed [q2e_pkg::TERM_W-1:0] cosy
);
  import q2e_pkg::*;

  logic v1;
  logic signed [31:0] wx, yz, xx, yy, zz, wy, zx, wz, xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    wx <= w * x;
    yz <= y * z;
    xx <= x * x;
    yy <= y * y;
    zz <= z * z;
    wy <= w * y;
    zx <= z * x;
    wz <= w * z;
    xy <= x * y;
    sinr <= (TERM_W'(wx) + TERM_W'(yz)) <<< 1;
    cosr <= ONE_Q28 - ((TERM_W'(xx) + TERM_W'(yy)) <<< 1);
    sinp <= (TERM_W'(wy) - TERM_W'(zx)) <<< 1;
    siny <= (TERM_W'(wz) + TERM_W'(xy)) <<< 1;
    cosy <= ONE_Q28 - ((TERM_W'(yy) + TERM_W'(zz)) <<< 1);
  end
endmodule

// File: rtl/core/q2e_isqrt.sv
// Pipelined restoring square root, one result bit per stage; also
// carries sinp and the saturation flag alongside.
module q2e_isqrt (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [q2e_pkg::TERM_W-1:0] sinp,
  output logic out_valid,
  output logic signed [q2e_pkg::TERM_W-1:0] sinp_out,
  output logic sat,
  output logic [q2e_pkg::ROOT_W-1:0] root
);
  import q2e_pkg::*;

  localparam int unsigned NST = ROOT_W;
  localparam int unsigned RW = SQ_W + 1;

  logic [NST:0] v;
  logic [RW-1:0] rem [NST+1];
  logic [ROOT_W-1:0] r [NST+1];
  logic signed [TERM_W-1:0] sp [NST+1];
  logic sf [NST+1];
  logic signed [TERM_W-1:0] mag;
  logic [55:0] sq;

  // only used when |sinp| < 2^28, so the low 28 bits carry the magnitude
  always_comb begin
    mag = sinp[TERM_W-1] ? -sinp : sinp;
    sq = mag[27:0] * mag[27:0];
  end

  // stage 0: saturation test and radicand
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
    sf[0] <= (sinp >= ONE_Q28) || (sinp <= -ONE_Q28);
    sp[0] <= sinp;
    rem[0] <= ((sinp >= ONE_Q28) || (sinp <= -ONE_Q28)) ? '0 :
              (RW'(1) << 56) - RW'(sq);
    r[0] <= '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_sq
    localparam int unsigned SH = 2 * (NST - 1 - s);
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else v[s+1] <= v[s];
      sf[s+1] <= sf[s];
      sp[s+1] <= sp[s];
      if (rem[s] >= (RW'({r[s], 2'b01}) << SH)) begin
        rem[s+1] <= rem[s] - (RW'({r[s], 2'b01}) << SH);
        r[s+1] <= {r[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem[s+1] <= rem[s];
        r[s+1] <= {r[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[NST];
  assign sinp_out = sp[NST];
  assign sat = sf[NST];
  assign root = r[NST];
endmodule

// File: rtl/core/q2e_cordic.sv
// Vectoring CORDIC atan2, prerotation stage plus one register per step,
// then rounding. Q3.13 result, clamped to +/-LIM; zero when both inputs are zero.
module q2e_cordic #(
  parameter int unsigned STEPS = q2e_pkg::CORDIC_STEPS_DEF,
  parameter logic signed [17:0] LIM = q2e_pkg::PI_Q13
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [q2e_pkg::TERM_W-1:0] y_in,
  input  logic signed [q2e_pkg::TERM_W-1:0] x_in,
  output logic out_valid,
  output logic signed [15:0] angle
);
  import q2e_pkg::*;

  localparam int unsigned N = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

  cordic_t st [N+1];
  logic [N+1:0] v;
  logic signed [CW-1:0] xe, ye;
  logic signed [ACC_W:0] rnd;
  logic signed [17:0] q;

  always_comb begin
    xe = CW'(x_in);
    ye = CW'(y_in);
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
    st[0].zero <= (x_in == '0) && (y_in == '0);
    if (x_in[TERM_W-1]) begin
      if (!y_in[TERM_W-1]) begin
        st[0].x <= ye; st[0].y <= -xe; st[0].acc <= HALF_PI_Q30;
      end else begin
        st[0].x <= -ye; st[0].y <= xe; st[0].acc <= -HALF_PI_Q30;
      end
    end else begin
      st[0].x <= xe; st[0].y <= ye; st[0].acc <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      st[i+1].zero <= st[i].zero;
      if (!st[i].y[CW-1] && st[i].y != '0) begin
        st[i+1].x <= st[i].x + (st[i].y >>> i);
        st[i+1].y <= st[i].y - (st[i].x >>> i);
        st[i+1].acc <= st[i].acc + atan_tab(i);
      end else begin
        st[i+1].x <= st[i].x - (st[i].y >>> i);
        st[i+1].y <= st[i].y + (st[i].x >>> i);
        st[i+1].acc <= st[i].acc - atan_tab(i);
      end
    end
  end

  always_comb begin
    rnd = (ACC_W+1)'(st[N].acc) + (ACC_W+1)'(65536);
    q = 18'(rnd >>> 17);
  end

  always_ff @(posedge clk) begin
    if (rst) v[N+1] <= 1'b0;
    else v[N+1] <= v[N];
    if (st[N].zero) angle <= '0;
    else if (q > LIM) angle <= 16'(LIM);
    else if (q < -LIM) angle <= 16'(-LIM);
    else angle <= 16'(q);
  end

  assign out_valid = v[N+1];
endmodule

// File: rtl/core/quaternion_to_euler_angles_top.sv
// The pitch path (terms, root, then CORDIC) sets the delay from start to done;
// roll and yaw are delayed to match.
// Throughput: one transaction per cycle; busy is always low; fully pipelined.
// Reset (rst, synchronous): clears all valid bits, done goes low; data is not reset.
// The receiver cannot stall: done is high for exactly one cycle per result.
module quaternion_to_euler_angles_top #(
  parameter int unsigned CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic done,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);
  import q2e_pkg::*;

  localparam int unsigned DLY = ROOT_W + 1;
  localparam int unsigned NC = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  logic tv, sv, rv, yv, pv;
  logic signed [TERM_W-1:0] sinr, cosr, sinp, siny, cosy, sp_d;
  logic sat;
  logic [ROOT_W-1:0] root;
  logic signed [TERM_W-1:0] dr_s [DLY], dr_c [DLY], dy_s [DLY], dy_c [DLY];
  logic [DLY-1:0] dv;
  logic signed [15:0] roll_q, yaw_q, pitch_q;
  logic [NC+1:0] satd;
  logic [NC+1:0] sgnd;

  assign busy = 1'b0;

  q2e_terms u_terms (
    .clk, .rst, .in_valid(start), .x(quat_x), .y(quat_y), .z(quat_z), .w(quat_w),
    .out_valid(tv), .sinr, .cosr, .sinp, .siny, .cosy
  );

  q2e_isqrt u_sqrt (
    .clk, .rst, .in_valid(tv), .sinp, .out_valid(sv), .sinp_out(sp_d), .sat, .root
  );

  // match roll/yaw to the root latency
  always_ff @(posedge clk) begin
    if (rst) dv <= '0;
    else dv <= {dv[DLY-2:0], tv};
    dr_s[0] <= sinr; dr_c[0] <= cosr; dy_s[0] <= siny; dy_c[0] <= cosy;
    for (int k = 1; k < DLY; k++) begin
      dr_s[k] <= dr_s[k-1]; dr_c[k] <= dr_c[k-1];
      dy_s[k] <= dy_s[k-1]; dy_c[k] <= dy_c[k-1];
    end
  end

  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_roll (
    .clk, .rst, .in_valid(dv[DLY-1]), .y_in(dr_s[DLY-1]), .x_in(dr_c[DLY-1]),
    .out_valid(rv), .angle(roll_q)
  );
  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_yaw (
    .clk, .rst, .in_valid(dv[DLY-1]), .y_in(dy_s[DLY-1]), .x_in(dy_c[DLY-1]),
    .out_valid(yv), .angle(yaw_q)
  );
  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(HALF_PI_Q13)) u_pitch (
    .clk, .rst, .in_valid(sv), .y_in(sp_d), .x_in(TERM_W'(root)),
    .out_valid(pv), .angle(pitch_q)
  );

  // saturation flag and sign follow the pitch CORDIC (NC+2 stages)
  always_ff @(posedge clk) begin
    satd <= {satd[NC:0], sat};
    sgnd <= {sgnd[NC:0], sp_d[TERM_W-1]};
  end

  assign done = pv & rv & yv;
  assign roll_angle = roll_q;
  assign yaw_angle = yaw_q;
  assign pitch_angle = satd[NC+1] ? (sgnd[NC+1] ? -15'(HALF_PI_Q13) : 15'(HALF_PI_Q13))
                                  : pitch_q[14:0];
endmodule

// File: rtl/core/q2e_checker.sv
module q2e_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle
);
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy) else $error("busy");
  a_roll: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)) else $error("roll");
  a_yaw: assert property (@(posedge clk) disable iff (rst)
    done |-> (yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)) else $error("yaw");
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)) else $error("pitch");
  a_rst: assert property (@(posedge clk) (!rst && $past(rst)) |-> !done)
    else $error("done after reset");
endmodule

bind quaternion_to_euler_angles_top q2e_checker u_chk (
  .clk, .rst, .start, .busy, .done, .roll_angle, .pitch_angle, .yaw_angle
);
